// ===== sv/fxalu_pkg.sv =====
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared constants, opcodes and the pipeline word type for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DW        = 32;
    localparam int NUM_W     = DW + FRAC_BITS;   // dividend magnitude width
    localparam int Q_W       = NUM_W + 1;        // quotient bits incl. half bit

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_INC  = 4'd4,
        OP_DEC  = 4'd5,
        OP_MIN  = 4'd6,
        OP_MAX  = 4'd7,
        OP_CMP  = 4'd8,
        OP_FINT = 4'd9,
        OP_TINT = 4'd10
    } t_op;

    // word travelling down the divider chain
    typedef struct packed {
        logic               vld;
        logic [DW-1:0]      res;      // result for non-divide ops
        logic               ovf;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               is_div;
        logic               dbz;
        logic               neg;
        logic [Q_W-1:0]     num;      // dividend bits, shifted out MSB first
        logic [DW-1:0]      den;      // |b|
        logic [DW:0]        rem;      // partial remainder
        logic [Q_W-1:0]     quo;
    } t_word;

endpackage

// ===== sv/fxalu_front.sv =====
// ----------------------------------------------------------------------------
// fxalu_front
// Decodes an operation, computes all non-divide results with saturation,
// and prepares the divide operands for the restoring divider chain.
// Two register stages: the multiply is registered before rounding.
// ----------------------------------------------------------------------------
module fxalu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [3:0]                   i_opcode,
    input  logic signed [31:0]           i_a,
    input  logic signed [31:0]           i_b,
    output fxalu_pkg::t_word             o_word
);

    localparam int FB = fxalu_pkg::FRAC_BITS;

    // stage 1
    logic                 r_vld;
    logic [3:0]           r_op;
    logic signed [31:0]   r_a;
    logic signed [31:0]   r_b;
    logic signed [63:0]   r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= i_opcode;
            r_a    <= i_a;
            r_b    <= i_b;
            r_prod <= i_a * i_b;
        end
    end

    // stage 2 logic
    logic signed [33:0] s_wide;
    logic [63:0]        p_mag;
    logic [63:0]        p_rnd;
    logic signed [65:0] m_wide;
    logic signed [65:0] f_wide;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    fxalu_pkg::t_word   n_word;
    fxalu_pkg::t_word   r_word;

    function automatic logic [32:0] sat(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       sat = {1'b1, 32'h7fffffff};
        else if (v < -66'sd2147483648) sat = {1'b1, 32'h80000000};
        else                           sat = {1'b0, v[31:0]};
    endfunction

    always_comb begin
        logic [32:0] sr;
        n_word        = '0;
        n_word.vld    = r_vld;
        n_word.gt     = r_a > r_b;
        n_word.lt     = r_a < r_b;
        n_word.eq     = r_a == r_b;
        p_mag  = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        p_rnd  = (p_mag + (64'd1 << (FB - 1))) >> FB;
        m_wide = r_prod[63] ? -$signed({2'b00, p_rnd}) : $signed({2'b00, p_rnd});
        f_wide = 66'(r_a) <<< FB;
        a_mag  = r_a[31] ? 32'(-r_a) : 32'(r_a);
        b_mag  = r_b[31] ? 32'(-r_b) : 32'(r_b);
        s_wide = '0;
        sr     = '0;
        case (r_op)
            fxalu_pkg::OP_ADD: begin
                s_wide = 34'(r_a) + 34'(r_b);
                sr = sat(66'(s_wide));
            end
            fxalu_pkg::OP_SUB: begin
                s_wide = 34'(r_a) - 34'(r_b);
                sr = sat(66'(s_wide));
            end
            fxalu_pkg::OP_INC: begin
                s_wide = 34'(r_a) + 34'sd1;
                sr = sat(66'(s_wide));
            end
            fxalu_pkg::OP_DEC: begin
                s_wide = 34'(r_a) - 34'sd1;
                sr = sat(66'(s_wide));
            end
            fxalu_pkg::OP_MUL:  sr = sat(m_wide);
            fxalu_pkg::OP_FINT: sr = sat(f_wide);
            fxalu_pkg::OP_MIN:  sr = {1'b0, (r_a >= r_b) ? r_b : r_a};
            fxalu_pkg::OP_MAX:  sr = {1'b0, (r_a >= r_b) ? r_a : r_b};
            fxalu_pkg::OP_CMP:  sr = {1'b0, r_a};
            fxalu_pkg::OP_TINT: sr = {1'b0, 32'(r_a >>> FB)};
            fxalu_pkg::OP_DIV: begin
                n_word.is_div = 1'b1;
                n_word.dbz    = (r_b == 0);
            end
            default: sr = '0;
        endcase
        n_word.ovf = sr[32];
        n_word.res = sr[31:0];
        n_word.neg = r_a[31] ^ r_b[31];
        // 2*|a|<<FB over |b|: one extra quotient bit gives the rounding half
        n_word.num = {a_mag, {FB{1'b0}}, 1'b0};
        n_word.den = b_mag;
        n_word.rem = '0;
        n_word.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== sv/fxalu_cell.sv =====
// ----------------------------------------------------------------------------
// fxalu_cell
// One restoring-division step: shifts in a dividend bit, subtracts the
// divisor when it fits, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module fxalu_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fxalu_pkg::t_word  i_word,
    output fxalu_pkg::t_word  o_word
);

    localparam int DW  = fxalu_pkg::DW;
    localparam int Q_W = fxalu_pkg::Q_W;

    fxalu_pkg::t_word n_word;
    fxalu_pkg::t_word r_word;
    logic [DW+1:0]    trial;
    logic [DW+1:0]    sh;

    always_comb begin
        n_word = i_word;
        sh     = {i_word.rem, i_word.num[Q_W-1]};
        trial  = sh - {2'b00, i_word.den};
        n_word.num = {i_word.num[Q_W-2:0], 1'b0};
        if (!trial[DW+1]) begin
            n_word.rem = trial[DW:0];
            n_word.quo = {i_word.quo[Q_W-2:0], 1'b1};
        end else begin
            n_word.rem = sh[DW:0];
            n_word.quo = {i_word.quo[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== sv/fixed_point_alu_q24_8.sv =====
// From input accept to output valid a word passes two front stages, 41 divider
// cells and the output register, the first loaded at the accept edge.
// Throughput: one word per cycle; a row of 41 divider cells (one quotient
// bit each, 32 + FRAC_BITS + 1 bits) sets the depth, all ops share it.
// The whole pipe stalls only when the output register is full and not taken.
// Synchronous active-low reset clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 ALU with saturation, rounding multiply and pipelined divide.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_opcode,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [31:0]  o_result,
    output logic                o_is_greater,
    output logic                o_is_less,
    output logic                o_is_equal,
    output logic                o_overflow,
    output logic                o_divide_by_zero
);

    localparam int Q_W = fxalu_pkg::Q_W;

    logic en;
    fxalu_pkg::t_word w [Q_W+1];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    fxalu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_valid),
        .i_opcode (i_opcode),
        .i_a      (i_operand_a),
        .i_b      (i_operand_b),
        .o_word   (w[0])
    );

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        fxalu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w[g]),
            .o_word  (w[g+1])
        );
    end

    // final rounding: quotient q2 = floor(2n/d); rounded = (q2 + 1) >> 1
    fxalu_pkg::t_word  last;
    logic [Q_W-1:0]    q_rnd;
    logic signed [65:0] q_sgn;
    logic [31:0]       n_res;
    logic              n_ovf;
    logic              r_valid;
    logic [31:0]       r_res;
    logic              r_gt, r_lt, r_eq, r_ovf, r_dbz;

    assign last  = w[Q_W];
    // (2n + d)/(2d) equals floor((floor(2n/d) + 1) / 2)
    assign q_rnd = Q_W'((Q_W+1)'(last.quo) + (Q_W+1)'(1)) >> 1;

    always_comb begin
        q_sgn = last.neg ? -$signed({25'd0, q_rnd}) : $signed({25'd0, q_rnd});
        n_res = last.res;
        n_ovf = last.ovf;
        if (last.is_div) begin
            if (last.dbz) begin
                n_res = '0;
                n_ovf = 1'b0;
            end else if (q_sgn > 66'sd2147483647) begin
                n_res = 32'h7fffffff;
                n_ovf = 1'b1;
            end else if (q_sgn < -66'sd2147483648) begin
                n_res = 32'h80000000;
                n_ovf = 1'b1;
            end else begin
                n_res = q_sgn[31:0];
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_ovf <= n_ovf;
            r_dbz <= last.is_div & last.dbz;
            r_gt  <= last.gt;
            r_lt  <= last.lt;
            r_eq  <= last.eq;
        end
    end

    assign o_valid          = r_valid;
    assign o_result         = r_res;
    assign o_is_greater     = r_gt;
    assign o_is_less        = r_lt;
    assign o_is_equal       = r_eq;
    assign o_overflow       = r_ovf;
    assign o_divide_by_zero = r_dbz;

endmodule

// ===== bench/fxalu_checker.sv =====
// ----------------------------------------------------------------------------
// fxalu_checker
// Watches both channels of the Q24.8 ALU, predicts each result word with
// exact integer arithmetic and compares it field by field.
// ----------------------------------------------------------------------------
module fxalu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  logic signed [31:0] i_result,
    input  logic               i_is_greater,
    input  logic               i_is_less,
    input  logic               i_is_equal,
    input  logic               i_overflow,
    input  logic               i_divide_by_zero,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = fxalu_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] res;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               ovf;
        logic               dbz;
    } t_alu_out;

    t_alu_out alu_expected_q[$];
    int       fail_count  = 0;
    int       checked     = 0;
    int       pending_cnt = 0;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    function automatic longint saturate(input longint v, inout logic ovf);
        if (v > S32_MAX) begin
            ovf = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            ovf = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic t_alu_out predict_alu(input logic [3:0] op,
                                             input logic signed [31:0] a32,
                                             input logic signed [31:0] b32);
        longint   a, b, r, p;
        longint unsigned m, n, d, q;
        logic     ovf;
        t_alu_out o;
        a   = a32;
        b   = b32;
        r   = 0;
        ovf = 1'b0;
        o   = '0;
        case (op)
            fxalu_pkg::OP_ADD: r = saturate(a + b, ovf);
            fxalu_pkg::OP_SUB: r = saturate(a - b, ovf);
            fxalu_pkg::OP_MUL: begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (64'd1 << (FB - 1))) >> FB;
                r = saturate((p < 0) ? -longint'(m) : longint'(m), ovf);
            end
            fxalu_pkg::OP_DIV: begin
                if (b == 0) begin
                    o.dbz = 1'b1;
                end else begin
                    n = ((a < 0) ? -a : a) << FB;
                    d = (b < 0) ? -b : b;
                    q = (2 * n + d) / (2 * d);
                    r = saturate(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), ovf);
                end
            end
            fxalu_pkg::OP_INC:  r = saturate(a + 1, ovf);
            fxalu_pkg::OP_DEC:  r = saturate(a - 1, ovf);
            fxalu_pkg::OP_MIN:  r = (a >= b) ? b : a;
            fxalu_pkg::OP_MAX:  r = (a >= b) ? a : b;
            fxalu_pkg::OP_CMP:  r = a;
            fxalu_pkg::OP_FINT: r = saturate(a * (64'sd1 <<< FB), ovf);
            fxalu_pkg::OP_TINT: r = a >>> FB;
            default: r = 0;
        endcase
        o.res = r[31:0];
        o.gt  = a > b;
        o.lt  = a < b;
        o.eq  = a == b;
        o.ovf = ovf;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        fail_count++;
        $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && i_valid && i_ready_in)
            alu_expected_q.push_back(predict_alu(i_opcode, i_operand_a, i_operand_b));
        if (i_rst_n && i_valid_out && i_ready) begin
            if (alu_expected_q.size() == 0) begin
                report_mismatch("unexpected word", i_result, 0);
            end else begin
                want = alu_expected_q.pop_front();
                checked++;
                if (i_result !== want.res)
                    report_mismatch("result", i_result, want.res);
                if (i_is_greater !== want.gt)
                    report_mismatch("is_greater", i_is_greater, want.gt);
                if (i_is_less !== want.lt)
                    report_mismatch("is_less", i_is_less, want.lt);
                if (i_is_equal !== want.eq)
                    report_mismatch("is_equal", i_is_equal, want.eq);
                if (i_overflow !== want.ovf)
                    report_mismatch("overflow", i_overflow, want.ovf);
                if (i_divide_by_zero !== want.dbz)
                    report_mismatch("divide_by_zero", i_divide_by_zero, want.dbz);
            end
        end
        pending_cnt = alu_expected_q.size();
    end

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked;

endmodule

// ===== bench/tb_fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8
// Drives directed corner operations, then random operand streams with
// random idle bursts on both sides; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 44;
    localparam int N_RANDOM  = 1880;
    localparam int CYC_LIMIT = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [3:0]         i_opcode = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_result;
    logic               o_is_greater, o_is_less, o_is_equal;
    logic               o_overflow, o_divide_by_zero;
    int                 fail_count, pending, checked;
    int                 cycles = 0;
    logic               quiet = 1'b0;   // no idling in the closing stretch

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fixed_point_alu_q24_8 dut (.*);

    fxalu_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_opcode,
        .i_operand_a, .i_operand_b, .i_valid_out(o_valid), .i_ready,
        .i_result(o_result), .i_is_greater(o_is_greater), .i_is_less(o_is_less),
        .i_is_equal(o_is_equal), .i_overflow(o_overflow),
        .i_divide_by_zero(o_divide_by_zero), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked)
    );

    // receiver: ready with random stall bursts
    always @(posedge i_clk) begin
        int stall;
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        if (stall > 0) begin
            stall--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 7) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return 32'($signed(16'($urandom)));   // moderate magnitudes
            4: return 32'($signed(24'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [3:0] op, input logic [31:0] a,
                             input logic [31:0] b);
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [3:0] op;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_word(fxalu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1);
        send_word(fxalu_pkg::OP_SUB, 32'h8000_0000, 32'd1);
        send_word(fxalu_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_word(fxalu_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);   // exact product, no rounding tie
        send_word(fxalu_pkg::OP_MUL, 32'd1, 32'h0000_0080);
        send_word(fxalu_pkg::OP_DIV, 32'h0000_1234, 32'd0);
        send_word(fxalu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(fxalu_pkg::OP_DIV, 32'd1, 32'd512);                 // exact half
        send_word(fxalu_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd3);
        send_word(fxalu_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(fxalu_pkg::OP_INC, 32'h7FFF_FFFF, 32'd0);
        send_word(fxalu_pkg::OP_DEC, 32'h8000_0000, 32'd0);
        send_word(fxalu_pkg::OP_MIN, 32'd5, 32'd5);
        send_word(fxalu_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(fxalu_pkg::OP_CMP, 32'hFFFF_FFFF, 32'd1);
        send_word(fxalu_pkg::OP_FINT, 32'h0080_0000, 32'd0);
        send_word(fxalu_pkg::OP_FINT, 32'hFF7F_FFFF, 32'd0);
        send_word(fxalu_pkg::OP_TINT, 32'hFFFF_FFFF, 32'd0);
        send_word(fxalu_pkg::OP_TINT, 32'h8000_0000, 32'd0);
        send_word(4'd11, 32'd7, 32'd3);
        send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // hold off until the pipe has drained
        i_valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 300)
                quiet = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(0, 10));
            send_word(op, pick_operand(), pick_operand());
        end
        i_valid <= 1'b0;

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d result words over all opcodes, operand extremes,",
                 checked);
        $display("saturation, rounding ties and divide by zero, with random idling.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
